@@ design/c_source_comment_strip_minify_assert.svh @@
// Assertion macros for the C comment stripper and minifier.
`ifndef C_SOURCE_COMMENT_STRIP_MINIFY_ASSERT_SVH
`define C_SOURCE_COMMENT_STRIP_MINIFY_ASSERT_SVH
`ifndef SYNTHESIS
`define CSM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csm assertion failed");
`define CSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csm assertion failed");
`else
`define CSM_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CSM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/csm_pkg.sv @@
// Types, codes and helper functions for the C comment stripper and minifier.
`timescale 1ns / 1ps
`default_nettype none
package csm_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;

   // strip stage modes
   localparam logic [2:0] MODE_NORMAL     = 3'd0;
   localparam logic [2:0] MODE_BLOCK      = 3'd1;
   localparam logic [2:0] MODE_BLOCK_STAR = 3'd2;
   localparam logic [2:0] MODE_LINE       = 3'd3;
   localparam logic [2:0] MODE_DQ         = 3'd4;
   localparam logic [2:0] MODE_SQ         = 3'd5;

   // squeeze stage quote modes
   localparam logic [1:0] QM_OUT = 2'd0;
   localparam logic [1:0] QM_DQ  = 2'd1;
   localparam logic [1:0] QM_SQ  = 2'd2;

   // held char of the strip stage is always a slash, so only its valid bit is kept
   typedef struct packed {
      logic [2:0] mode;
      logic       esc;
      logic       held_valid;
   } strip_state_type;

   typedef struct packed {
      logic [1:0] qmode;
      logic       esc;
      logic       directive;
      logic       prev_alnum;
      logic [7:0] hs_char;
      logic       hs_valid;
   } squeeze_state_type;

   typedef struct packed {
      logic [1:0] cnt;
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
   } emit_list_type;

   typedef struct packed {
      squeeze_state_type st;
      emit_list_type     em;
   } squeeze_result_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic emit_list_type push_emit(input emit_list_type e, input logic [7:0] c);
      emit_list_type r;
      r = e;
      case (e.cnt)
         2'd0: begin
            r.c0  = c;
            r.cnt = 2'd1;
         end
         2'd1: begin
            r.c1  = c;
            r.cnt = 2'd2;
         end
         2'd2: begin
            r.c2  = c;
            r.cnt = 2'd3;
         end
         default: r = e;
      endcase
      return r;
   endfunction

   function automatic squeeze_result_type squeeze_step(input squeeze_result_type a,
                                                       input logic [7:0] c);
      squeeze_result_type r;
      logic               keep_c;
      r      = a;
      keep_c = 1'b0;
      if (r.st.hs_valid) begin
         if (is_alnum(c)) begin
            r.em            = push_emit(r.em, r.st.hs_char);
            r.st.prev_alnum = is_alnum(r.st.hs_char);
         end
         r.st.hs_valid = 1'b0;
      end
      if (r.st.esc) begin
         r.st.esc = 1'b0;
         keep_c   = 1'b1;
      end else if (c == CH_BSLASH) begin
         r.st.esc = 1'b1;
         keep_c   = 1'b1;
      end else if ((c == CH_CR || c == CH_LF) && r.st.directive) begin
         r.st.directive = 1'b0;
         keep_c         = 1'b1;
      end else if (r.st.qmode == QM_DQ) begin
         if (c == CH_DQUOTE) r.st.qmode = QM_OUT;
         keep_c = 1'b1;
      end else if (r.st.qmode == QM_SQ) begin
         if (c == CH_SQUOTE) r.st.qmode = QM_OUT;
         keep_c = 1'b1;
      end else if (c == CH_DQUOTE) begin
         r.st.qmode = QM_DQ;
         keep_c     = 1'b1;
      end else if (c == CH_SQUOTE) begin
         r.st.qmode = QM_SQ;
         keep_c     = 1'b1;
      end else if (is_space(c)) begin
         if (r.st.prev_alnum) begin
            r.st.hs_char  = c;
            r.st.hs_valid = 1'b1;
         end
      end else begin
         if (c == CH_HASH) r.st.directive = 1'b1;
         keep_c = 1'b1;
      end
      if (keep_c) begin
         r.em            = push_emit(r.em, c);
         r.st.prev_alnum = is_alnum(c);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/csm_if.sv @@
// Byte stream channel interfaces for source bytes in and kept bytes out.
`timescale 1ns / 1ps
`default_nettype none
interface csm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;
   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface csm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;
   modport source (output valid, output out_char, output out_last, input ready);
   modport sink   (input valid, input out_char, input out_last, output ready);
endinterface
`default_nettype wire

@@ design/c_source_comment_strip_minify.sv @@
// Top level: C comment stripper and whitespace minifier on a byte stream.
// A byte transferred in is registered in the input stage, then written to the result queue.
// Throughput: one input byte per cycle while the 4-entry result queue has room for
//   three results, else the input stage holds the byte; one result byte per cycle.
// Reset: synchronous; clears strip/squeeze state, the input stage and the queue.
`timescale 1ns / 1ps
`default_nettype none
`include "c_source_comment_strip_minify_assert.svh"
module c_source_comment_strip_minify
   import csm_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   csm_req_if.sink     req_if,
   csm_rsp_if.source   rsp_if
);

   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_char_ff;
   logic              s1_last_ff;
   logic              s1_fire;
   logic              req_take;
   logic              rsp_pop;
   logic              space_ok;

   strip_state_type    st_ff, st_in, st_nxt;
   squeeze_state_type  sq_ff, sq_in;
   squeeze_result_type r0, r1, r2, r3;
   logic               do_held, do_char, do_flush;

   logic [7:0]         fifo_char_ff [FIFO_DEPTH];
   logic               fifo_last_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [7:0]         slot_char [3];
   logic               slot_last [3];
   logic               slot_en   [3];

   localparam strip_state_type   STRIP_RESET   = '{mode: MODE_NORMAL, esc: 1'b0,
                                                   held_valid: 1'b0};
   localparam squeeze_state_type SQUEEZE_RESET = '{qmode: QM_OUT, esc: 1'b0,
                                                   directive: 1'b0, prev_alnum: 1'b0,
                                                   hs_char: 8'h00, hs_valid: 1'b0};

   // handshake
   assign rsp_pop  = rsp_if.valid && rsp_if.ready;
   assign space_ok = (count_ff <= CNT_W'(FIFO_DEPTH - 3)) ||
                     ((count_ff <= CNT_W'(FIFO_DEPTH - 2)) && rsp_pop);
   assign s1_fire  = s1_valid_ff && space_ok;
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign req_take = req_if.valid && req_if.ready;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_fire);

   // strip stage decisions
   always_comb begin
      st_nxt  = st_ff;
      do_held = 1'b0;
      do_char = 1'b0;
      if (st_ff.held_valid && s1_char_ff == CH_STAR) begin
         st_nxt.held_valid = 1'b0;
         st_nxt.mode       = MODE_BLOCK;
      end else if (st_ff.held_valid && s1_char_ff == CH_SLASH) begin
         st_nxt.held_valid = 1'b0;
         st_nxt.mode       = MODE_LINE;
      end else begin
         do_held           = st_ff.held_valid;
         st_nxt.held_valid = 1'b0;
         unique case (st_ff.mode) inside
            MODE_BLOCK: begin
               if (s1_char_ff == CH_STAR) st_nxt.mode = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               if (s1_char_ff == CH_SLASH) st_nxt.mode = MODE_NORMAL;
               else if (s1_char_ff != CH_STAR) st_nxt.mode = MODE_BLOCK;
            end
            MODE_LINE: begin
               if (st_ff.esc) begin
                  st_nxt.esc = 1'b0;
               end else if (s1_char_ff == CH_BSLASH) begin
                  st_nxt.esc = 1'b1;
               end else if (s1_char_ff == CH_CR || s1_char_ff == CH_LF) begin
                  st_nxt.mode = MODE_NORMAL;
                  do_char     = 1'b1;
               end
            end
            MODE_NORMAL, MODE_DQ, MODE_SQ: begin
               if (st_ff.esc) begin
                  st_nxt.esc = 1'b0;
                  do_char    = 1'b1;
               end else if (s1_char_ff == CH_BSLASH) begin
                  st_nxt.esc = 1'b1;
                  do_char    = 1'b1;
               end else if (s1_char_ff == CH_SLASH && st_ff.mode == MODE_NORMAL) begin
                  st_nxt.held_valid = 1'b1;
               end else begin
                  if (st_ff.mode == MODE_NORMAL) begin
                     if (s1_char_ff == CH_DQUOTE) st_nxt.mode = MODE_DQ;
                     else if (s1_char_ff == CH_SQUOTE) st_nxt.mode = MODE_SQ;
                  end else if (st_ff.mode == MODE_DQ && s1_char_ff == CH_DQUOTE) begin
                     st_nxt.mode = MODE_NORMAL;
                  end else if (st_ff.mode == MODE_SQ && s1_char_ff == CH_SQUOTE) begin
                     st_nxt.mode = MODE_NORMAL;
                  end
                  do_char = 1'b1;
               end
            end
            default: st_nxt = st_ff;
         endcase
      end
   end

   // squeeze chain: held slash, current byte, end-of-file slash flush
   always_comb begin
      r0.st    = sq_ff;
      r0.em    = '0;
      r1       = do_held ? squeeze_step(r0, CH_SLASH) : r0;
      r2       = do_char ? squeeze_step(r1, s1_char_ff) : r1;
      do_flush = s1_last_ff && st_nxt.held_valid;
      r3       = do_flush ? squeeze_step(r2, CH_SLASH) : r2;
   end

   always_comb begin
      if (s1_fire && s1_last_ff) begin
         st_in = STRIP_RESET;
         sq_in = SQUEEZE_RESET;
      end else if (s1_fire) begin
         st_in = st_nxt;
         sq_in = r3.st;
      end else begin
         st_in = st_ff;
         sq_in = sq_ff;
      end
   end

   // result queue writes
   always_comb begin
      slot_char[0] = r3.em.c0;
      slot_char[1] = r3.em.c1;
      slot_char[2] = r3.em.c2;
      for (int i = 0; i < 3; i++) begin
         slot_en[i]   = s1_fire && (2'(i) < r3.em.cnt);
         slot_last[i] = s1_last_ff && (2'(i) == r3.em.cnt - 2'd1);
      end
   end

   assign wr_ptr_in = s1_fire ? wr_ptr_ff + PTR_W'(r3.em.cnt) : wr_ptr_ff;
   assign rd_ptr_in = rsp_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + (s1_fire ? CNT_W'(r3.em.cnt) : CNT_W'(0))
                      - (rsp_pop ? CNT_W'(1) : CNT_W'(0));

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (slot_en[i]) begin
            fifo_char_ff[wr_ptr_ff + PTR_W'(i)] <= slot_char[i];
            fifo_last_ff[wr_ptr_ff + PTR_W'(i)] <= slot_last[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_if.in_char;
         s1_last_ff <= req_if.in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         st_ff       <= STRIP_RESET;
         sq_ff       <= SQUEEZE_RESET;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         st_ff       <= st_in;
         sq_ff       <= sq_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   assign rsp_if.valid    = (count_ff != '0);
   assign rsp_if.out_char = fifo_char_ff[rd_ptr_ff];
   assign rsp_if.out_last = fifo_last_ff[rd_ptr_ff];

   `CSM_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_W'(FIFO_DEPTH))
   `CSM_ASSERT_NEXT(a_eof_clears, clock, reset, s1_fire && s1_last_ff,
                    st_ff.mode == MODE_NORMAL && !st_ff.held_valid &&
                    !sq_ff.hs_valid && sq_ff.qmode == QM_OUT)
   `CSM_ASSERT_SAME(a_space_outside_quotes, clock, reset, sq_ff.hs_valid, sq_ff.qmode == QM_OUT)
   `CSM_ASSERT_SAME(a_slash_in_code, clock, reset, st_ff.held_valid, st_ff.mode == MODE_NORMAL)

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the C comment stripper and whitespace minifier.
`timescale 1ns / 1ps
module tb;
   import csm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 200;
   localparam int RANDOM_ITEMS = 130;

   typedef struct packed {
      logic [7:0] ch;
      logic       eof;
   } stream_byte_type;

   logic clock;
   logic reset;

   csm_req_if req_ch();
   csm_rsp_if rsp_ch();

   c_source_comment_strip_minify u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   stream_byte_type src_q[$];
   stream_byte_type kept_q[$];
   stream_byte_type nxt;
   stream_byte_type want;

   int n_err = 0;
   int n_sent = 0;
   int n_loaded = 0;
   int n_dir = 0;
   int total = 0;
   int quiet_from = 1 << 30;
   int hold_at = 1 << 30;
   int hold_cnt = 0;
   bit hold_done = 1'b0;
   bit pause_done = 1'b0;
   int drv_gap = 0;
   int rcv_gap = 0;
   int cycles = 0;
   wire quiet = (n_sent >= quiet_from);

   // predictor state
   logic [2:0] sm;
   logic       s_esc;
   logic       s_held;
   logic [1:0] qm;
   logic       q_esc;
   logic       dir;
   logic       prev_an;
   logic [7:0] hs_c;
   logic       hs_v;
   logic [7:0] step_buf[3];
   int         n_out;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      if (n_err < 50) $display("ERROR: %s", msg);
      n_err++;
   endtask

   function automatic bit alnum8(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
   endfunction

   function automatic bit ws8(input logic [7:0] c);
      return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
   endfunction

   function void clear_state();
      sm      = MODE_NORMAL;
      s_esc   = 1'b0;
      s_held  = 1'b0;
      qm      = QM_OUT;
      q_esc   = 1'b0;
      dir     = 1'b0;
      prev_an = 1'b0;
      hs_c    = 8'h00;
      hs_v    = 1'b0;
   endfunction

   function void put(input logic [7:0] c);
      if (n_out < 3) begin
         step_buf[n_out] = c;
         n_out++;
      end
      prev_an = alnum8(c);
   endfunction

   function void squeeze_byte(input logic [7:0] c);
      if (hs_v) begin
         if (alnum8(c)) put(hs_c);
         hs_v = 1'b0;
      end
      if (q_esc) begin
         q_esc = 1'b0;
         put(c);
      end else if (c == CH_BSLASH) begin
         q_esc = 1'b1;
         put(c);
      end else if ((c == CH_CR || c == CH_LF) && dir) begin
         dir = 1'b0;
         put(c);
      end else if (qm == QM_DQ) begin
         if (c == CH_DQUOTE) qm = QM_OUT;
         put(c);
      end else if (qm == QM_SQ) begin
         if (c == CH_SQUOTE) qm = QM_OUT;
         put(c);
      end else if (c == CH_DQUOTE) begin
         qm = QM_DQ;
         put(c);
      end else if (c == CH_SQUOTE) begin
         qm = QM_SQ;
         put(c);
      end else if (ws8(c)) begin
         if (prev_an) begin
            hs_c = c;
            hs_v = 1'b1;
         end
      end else begin
         if (c == CH_HASH) dir = 1'b1;
         put(c);
      end
   endfunction

   function void strip_byte(input logic [7:0] c);
      if (s_held) begin
         s_held = 1'b0;
         if (c == CH_STAR) begin
            sm = MODE_BLOCK;
            return;
         end
         if (c == CH_SLASH) begin
            sm = MODE_LINE;
            return;
         end
         squeeze_byte(CH_SLASH);
      end
      if (sm == MODE_BLOCK) begin
         if (c == CH_STAR) sm = MODE_BLOCK_STAR;
         return;
      end
      if (sm == MODE_BLOCK_STAR) begin
         if (c == CH_SLASH) sm = MODE_NORMAL;
         else if (c != CH_STAR) sm = MODE_BLOCK;
         return;
      end
      if (sm == MODE_LINE) begin
         if (s_esc) begin
            s_esc = 1'b0;
         end else if (c == CH_BSLASH) begin
            s_esc = 1'b1;
         end else if (c == CH_CR || c == CH_LF) begin
            sm = MODE_NORMAL;
            squeeze_byte(c);
         end
         return;
      end
      if (s_esc) begin
         s_esc = 1'b0;
         squeeze_byte(c);
         return;
      end
      if (c == CH_BSLASH) begin
         s_esc = 1'b1;
         squeeze_byte(c);
      end else if (c == CH_SLASH && sm == MODE_NORMAL) begin
         s_held = 1'b1;
      end else begin
         if (sm == MODE_NORMAL) begin
            if (c == CH_DQUOTE) sm = MODE_DQ;
            else if (c == CH_SQUOTE) sm = MODE_SQ;
         end else if (sm == MODE_DQ && c == CH_DQUOTE) begin
            sm = MODE_NORMAL;
         end else if (sm == MODE_SQ && c == CH_SQUOTE) begin
            sm = MODE_NORMAL;
         end
         squeeze_byte(c);
      end
   endfunction

   // expected kept bytes for one source byte
   function void minify_byte(input logic [7:0] c, input logic eof);
      stream_byte_type r;
      n_out = 0;
      strip_byte(c);
      if (eof) begin
         if (s_held) begin
            s_held = 1'b0;
            squeeze_byte(CH_SLASH);
         end
         hs_v = 1'b0;
      end
      for (int i = 0; i < n_out; i++) begin
         r.ch  = step_buf[i];
         r.eof = eof && (i == n_out - 1);
         kept_q.insert(kept_q.size(), r);
      end
      if (eof) clear_state();
   endfunction

   task automatic push_byte(input logic [7:0] c);
      stream_byte_type b;
      b.ch  = c;
      b.eof = 1'b0;
      src_q.insert(src_q.size(), b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic mark_eof();
      stream_byte_type b;
      b = src_q.pop_back();
      b.eof = 1'b1;
      src_q.insert(src_q.size(), b);
   endtask

   task automatic push_ident();
      string alnum_set;
      int n;
      alnum_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) push_byte(alnum_set[$urandom_range(0, 61)]);
   endtask

   task automatic push_ws();
      logic [7:0] ws_set[6];
      ws_set = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
      push_byte(ws_set[$urandom_range(0, 5)]);
   endtask

   task automatic push_body(input int max_n);
      string body_set;
      int n;
      body_set = "ab */\\\"'\n 9#/*";
      n = $urandom_range(0, max_n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 5) == 0) push_byte(8'($urandom_range(0, 255)));
         else push_byte(body_set[$urandom_range(0, body_set.len() - 1)]);
      end
   endtask

   task automatic add_token();
      string punct_set;
      int n;
      punct_set = "+-*/;(){}=<>,!&|";
      case ($urandom_range(0, 9))
         0: begin
            push_ident();
         end
         1: begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) push_ws();
         end
         2: begin
            push_text("/*");
            push_body(5);
            push_text("*/");
         end
         3: begin
            push_text("//");
            push_body(4);
            if ($urandom_range(0, 3) == 0) push_text("\\\n");
            if ($urandom_range(0, 1) == 0) push_byte(CH_LF);
            else push_byte(CH_CR);
         end
         4: begin
            push_byte(CH_DQUOTE);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(0, 3))
                  0: push_ident();
                  1: push_ws();
                  2: push_text("\\\"");
                  default: push_body(1);
               endcase
            end
            push_byte(CH_DQUOTE);
         end
         5: begin
            push_byte(CH_SQUOTE);
            if ($urandom_range(0, 2) == 0) push_text("\\'");
            else push_byte(8'($urandom_range(0, 255)));
            push_byte(CH_SQUOTE);
         end
         6: begin
            push_byte(CH_HASH);
            push_ident();
            push_ws();
            push_ident();
            if ($urandom_range(0, 2) == 0) push_text(" /* x */ ");
            if ($urandom_range(0, 1) == 0) push_byte(CH_LF);
            else push_byte(CH_CR);
         end
         7: begin
            push_text("\\\n");
         end
         8: begin
            push_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
         end
         default: begin
            push_byte(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   task automatic build_stimulus();
      int n;
      push_text("a /*/\\*/b");
      mark_eof();
      push_text("#//\\\n\r");
      mark_eof();
      push_text("\"/*\"\\\n/");
      mark_eof();
      push_byte(CH_SQUOTE);
      push_byte(8'hFF);
      push_byte(CH_SQUOTE);
      push_byte(8'h00);
      push_byte(8'h20);
      mark_eof();
      n_dir = src_q.size();
      while (src_q.size() < n_dir + RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(2, 8);
            for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
         end else begin
            n = $urandom_range(3, 10);
            for (int i = 0; i < n; i++) add_token();
         end
         mark_eof();
      end
   endtask

   // source side
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            minify_byte(req_ch.in_char, req_ch.in_last);
            n_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_ch.valid <= 1'b0;
            end else if (!pause_done && n_loaded == n_dir &&
                         (kept_q.size() != 0 || n_sent != n_loaded)) begin
               req_ch.valid <= 1'b0;
            end else if (src_q.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (!quiet && hold_cnt == 0 && $urandom_range(0, 9) == 0) begin
               drv_gap = $urandom_range(0, 15);
               req_ch.valid <= 1'b0;
            end else begin
               if (n_loaded == n_dir) pause_done = 1'b1;
               nxt = src_q.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.in_char <= nxt.ch;
               req_ch.in_last <= nxt.eof;
               n_loaded++;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (!hold_done && n_sent >= hold_at) begin
         hold_cnt  <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (kept_q.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer char=%02h last=%0b",
                                         rsp_ch.out_char, rsp_ch.out_last));
            end else begin
               want = kept_q.pop_front();
               if (rsp_ch.out_char !== want.ch)
                  report_mismatch($sformatf("out_char %02h, expected %02h",
                                            rsp_ch.out_char, want.ch));
               if (rsp_ch.out_last !== want.eof)
                  report_mismatch($sformatf("out_last %0b, expected %0b (char %02h)",
                                            rsp_ch.out_last, want.eof, want.ch));
            end
         end
         if (hold_cnt != 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (rcv_gap > 0) begin
            rcv_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rcv_gap = $urandom_range(0, 15);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.in_char = 8'h00;
      req_ch.in_last = 1'b0;
      rsp_ch.ready   = 1'b0;
      clear_state();
      build_stimulus();
      total      = src_q.size();
      quiet_from = total - total / 6;
      hold_at    = n_dir + 40;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (n_sent != total || kept_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (kept_q.size() != 0)
         report_mismatch($sformatf("%0d expected transfers never arrived", kept_q.size()));
      if (n_err == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/csm_pkg.sv
design/csm_if.sv
design/c_source_comment_strip_minify.sv
tb/tb.sv
